// ----- rtl/can_receive_signal_mapper_top_defines.svh -----
// Assertion macros of the signal mapper top level
`ifndef CAN_RECEIVE_SIGNAL_MAPPER_TOP_DEFINES_SVH
`define CAN_RECEIVE_SIGNAL_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define CRSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crsm check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define CRSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crsm check failed");

`endif

// ----- rtl/crsm_pkg.sv -----
// Types and constants of the CAN receive signal mapper
package crsm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FRAME  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_OFFSET = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_MSGS_FULL  = 3'd3,
    ST_ITEMS_FULL = 3'd4,
    ST_NO_MATCH   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_RM_RD,
    S_RM_WR,
    S_RD,
    S_EXT,
    S_MUL,
    S_VAL,
    S_RESP
  } state_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  localparam logic [10:0] SERVICE_ID = 11'h601;
  localparam logic [3:0]  FRAME_LEN  = 4'd8;
  localparam logic [7:0]  OFS_MAX    = 8'd63;
  localparam logic [7:0]  LEN_MAX    = 8'd32;
  localparam int          WORD_BITS  = 32;

  // One stored signal item
  typedef struct packed {
    logic [7:0]  param;
    logic [15:0] gain;
    logic [5:0]  offset;
    logic [5:0]  length;
  } item_t;

  // Stage enables of the decode unit
  typedef struct packed {
    logic ext_en;
    logic mul_en;
  } dec_ctl_t;

endpackage

// ----- rtl/crsm_if.sv -----
// Handshake channels of the signal mapper: request words and result words
interface crsm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [10:0]        can_id;
  logic [3:0]         frame_length;
  logic [63:0]        frame_data;
  logic [7:0]         param_index;
  logic [7:0]         bit_offset;
  logic [7:0]         bit_length;
  logic signed [15:0] gain;

  modport source (output valid, op, can_id, frame_length, frame_data, param_index,
                  bit_offset, bit_length, gain, input ready);
  modport sink   (input valid, op, can_id, frame_length, frame_data, param_index,
                  bit_offset, bit_length, gain, output ready);
endinterface

interface crsm_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [2:0]         status;
  logic [3:0]         messages_used;
  logic [6:0]         removed_count;
  logic [7:0]         out_param;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, kind, status, messages_used, removed_count, out_param,
                  value, last, input ready);
  modport sink   (input valid, kind, status, messages_used, removed_count, out_param,
                  value, last, output ready);
endinterface

// ----- rtl/crsm_item_mem.sv -----
// Signal item store: one write port, one registered read port
module crsm_item_mem #(
  parameter int DEPTH = 80,
  parameter int AW    = 7
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  crsm_pkg::item_t     wdata,
  input  logic [AW-1:0]       raddr,
  output crsm_pkg::item_t     rdata
);
  import crsm_pkg::*;

  item_t mem [DEPTH];
  item_t rdata_r;

  // write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // register the read word
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/crsm_decode.sv -----
// Decode unit: field extraction stage, then fixed-point multiply stage
module crsm_decode #(
  parameter int FRAC_BITS = 5
) (
  input  logic               clk,
  input  crsm_pkg::dec_ctl_t ctl,
  input  crsm_pkg::item_t    entry,
  input  logic [63:0]        data,
  output logic [7:0]         param_o,
  output logic signed [31:0] value_o
);
  import crsm_pkg::*;

  logic [31:0]        word;
  logic [31:0]        shifted;
  logic [32:0]        mask33;
  logic [31:0]        fx;
  logic signed [31:0] fx_r;
  logic signed [15:0] gain_r;
  logic [7:0]         param_r;
  logic signed [47:0] prod;
  logic signed [47:0] prod_sh;
  logic signed [31:0] value_r;

  // pick the half word, shift down, mask to length, scale into fixed point
  always_comb begin
    word    = entry.offset[5] ? data[63:32] : data[31:0];
    shifted = word >> entry.offset[4:0];
    mask33  = (33'd1 << entry.length) - 33'd1;
    fx      = (shifted & mask33[31:0]) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ctl.ext_en) begin
      fx_r    <= fx;
      gain_r  <= entry.gain;
      param_r <= entry.param;
    end
  end

  // multiply, then floor shift back by the fraction bits
  assign prod    = fx_r * gain_r;
  assign prod_sh = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      value_r <= prod_sh[31:0];
    end
  end

  assign param_o = param_r;
  assign value_o = value_r;

endmodule

// ----- rtl/can_receive_signal_mapper_top.sv -----
// Top level of the CAN receive signal mapper: sequencer, message table, item store
//
//  channel | dir | handshake          | word
//  in_ch   | in  | valid/ready        | op, can_id, frame_length, frame_data, param, ...
//  out_ch  | out | valid/ready        | kind, status, counts, out_param, value, last
//
// One request at a time; ready only while idle. Clear replies the cycle after acceptance.
// Add scans the message ids, one per cycle, then writes the item in S_ADD, then replies.
// Remove walks every stored item through the item memory, a read (S_RM_RD) and a
// write-back (S_RM_WR) per item and an S_RM_RD step to close each message and to finish,
// then the reply. A frame scans the message ids to match, then steps each item through memory
// read, extract, multiply and result (S_RD to S_VAL); a stall on out_ch holds the result.
// Reset (synchronous, rst_n low) empties the table; no clearing pass is needed.
`include "can_receive_signal_mapper_top_defines.svh"

module can_receive_signal_mapper_top #(
  parameter int MAX_MSGS  = 10,
  parameter int MAX_ITEMS = 8,
  parameter int FRAC_BITS = 5
) (
  input logic       clk,
  input logic       rst_n,
  crsm_in_if.sink   in_ch,
  crsm_out_if.source out_ch
);
  import crsm_pkg::*;

  localparam int DEPTH = MAX_MSGS * MAX_ITEMS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
  localparam int MCW   = $clog2(MAX_MSGS + 1);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int RW    = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;

  // latched request
  op_t         op_r;
  logic [10:0] id_r;
  logic [7:0]  param_r;
  item_t       new_item_r;
  logic [63:0] data_r;

  // message table: valid entries always form a prefix of used_r slots
  logic [MCW-1:0] used_r;
  logic [10:0]    ids_r  [MAX_MSGS];
  logic [CW-1:0]  cnts_r [MAX_MSGS];

  logic [MCW-1:0] mi_r;
  logic [MCW-1:0] dst_r;
  logic [CW-1:0]  j_r;
  logic [CW-1:0]  k_r;
  logic [RW-1:0]  rem_r;
  logic           found_r;
  status_t        st_r;
  logic [3:0]     resp_used_r;

  logic [MW-1:0]  mi_idx;
  logic [MW-1:0]  dst_idx;
  logic           scan_end;
  logic           scan_hit;
  logic [CW-1:0]  cur_cnt;
  logic [CW-1:0]  add_cnt;
  logic           last_item;

  logic           in_acc;
  logic           out_acc;
  logic           mem_we;
  logic [AW-1:0]  waddr;
  item_t          wdata;
  logic [AW-1:0]  raddr;
  item_t          rdata;
  dec_ctl_t       dec_ctl;
  logic [7:0]     dec_param;
  logic signed [31:0] dec_value;

  assign mi_idx    = mi_r[MW-1:0];
  assign dst_idx   = dst_r[MW-1:0];
  assign scan_end  = (mi_r >= used_r);
  assign scan_hit  = !scan_end && (ids_r[mi_idx] == id_r);
  assign cur_cnt   = scan_end ? '0 : cnts_r[mi_idx];
  assign add_cnt   = found_r ? cur_cnt : '0;
  assign last_item = ((j_r + CW'(1)) == cur_cnt);

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // item addresses
  assign raddr = AW'(mi_idx * MAX_ITEMS) + AW'(j_r);
  always_comb begin
    if (state_r == S_RM_WR) begin
      waddr = AW'(dst_idx * MAX_ITEMS) + AW'(k_r);
      wdata = rdata;
    end else begin
      waddr = AW'(mi_idx * MAX_ITEMS) + AW'(add_cnt);
      wdata = new_item_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_ch.op))
            OP_CLEAR:  state_nxt = S_RESP;
            OP_REMOVE: state_nxt = S_RM_RD;
            OP_ADD: begin
              if (in_ch.bit_offset > OFS_MAX || in_ch.bit_length == 8'd0 ||
                  in_ch.bit_length > LEN_MAX) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_FRAME: begin
              if (in_ch.frame_length != FRAME_LEN || in_ch.can_id == SERVICE_ID) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = (op_r == OP_ADD) ? S_ADD : S_RD;
        end else if (scan_end) begin
          state_nxt = (op_r == OP_ADD) ? S_ADD : S_RESP;
        end
      end
      S_ADD:   state_nxt = S_RESP;
      S_RM_RD: begin
        if (scan_end) begin
          state_nxt = S_RESP;
        end else if (j_r < cur_cnt) begin
          state_nxt = S_RM_WR;
        end
      end
      S_RM_WR: state_nxt = S_RM_RD;
      S_RD:    state_nxt = S_EXT;
      S_EXT:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_VAL;
      S_VAL: begin
        if (out_acc) begin
          state_nxt = last_item ? S_IDLE : S_RD;
        end
      end
      S_RESP: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready    = 1'b0;
    mem_we         = 1'b0;
    dec_ctl.ext_en = 1'b0;
    dec_ctl.mul_en = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ch.ready    = 1'b1;
      S_ADD:   mem_we = found_r ? (cur_cnt < CW'(MAX_ITEMS)) : (used_r < MCW'(MAX_MSGS));
      S_RM_WR: mem_we = (rdata.param != param_r);
      S_EXT:   dec_ctl.ext_en = 1'b1;
      S_MUL:   dec_ctl.mul_en = 1'b1;
      default: ;
    endcase
  end

  // result word, held from registers while stalled
  always_comb begin
    out_ch.valid         = (state_r == S_RESP) || (state_r == S_VAL);
    out_ch.kind          = (state_r == S_VAL) ? KIND_VALUE : KIND_STATUS;
    out_ch.status        = (state_r == S_VAL) ? ST_OK : st_r;
    out_ch.messages_used = (state_r == S_VAL) ? 4'd0 : resp_used_r;
    out_ch.removed_count = (state_r == S_VAL) ? 7'd0 : 7'(rem_r);
    out_ch.out_param     = (state_r == S_VAL) ? dec_param : 8'd0;
    out_ch.value         = (state_r == S_VAL) ? dec_value : 32'sd0;
    out_ch.last          = (state_r == S_VAL) ? last_item : 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_acc && op_t'(in_ch.op) == OP_CLEAR) begin
        used_r <= '0;
      end else if (state_r == S_ADD && !found_r && used_r < MCW'(MAX_MSGS)) begin
        used_r <= used_r + MCW'(1);
      end else if (state_r == S_RM_RD && scan_end) begin
        used_r <= dst_r;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r              <= op_t'(in_ch.op);
          id_r              <= in_ch.can_id;
          param_r           <= in_ch.param_index;
          data_r            <= in_ch.frame_data;
          new_item_r.param  <= in_ch.param_index;
          new_item_r.gain   <= in_ch.gain;
          new_item_r.offset <= in_ch.bit_offset[5:0];
          new_item_r.length <= in_ch.bit_length[5:0];
          mi_r              <= '0;
          dst_r             <= '0;
          j_r               <= '0;
          k_r               <= '0;
          rem_r             <= '0;
          found_r           <= 1'b0;
          resp_used_r       <= 4'd0;
          if (op_t'(in_ch.op) == OP_ADD && in_ch.bit_offset > OFS_MAX) begin
            st_r <= ST_BAD_OFFSET;
          end else if (op_t'(in_ch.op) == OP_ADD &&
                       (in_ch.bit_length == 8'd0 || in_ch.bit_length > LEN_MAX)) begin
            st_r <= ST_BAD_LENGTH;
          end else if (op_t'(in_ch.op) == OP_FRAME) begin
            st_r <= ST_NO_MATCH;
          end else begin
            st_r <= ST_OK;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          found_r <= 1'b1;
        end else if (!scan_end) begin
          mi_r <= mi_r + MCW'(1);
        end
      end
      S_ADD: begin
        if (found_r) begin
          if (cur_cnt < CW'(MAX_ITEMS)) begin
            cnts_r[mi_idx] <= cur_cnt + CW'(1);
            resp_used_r    <= 4'(used_r);
          end else begin
            st_r <= ST_ITEMS_FULL;
          end
        end else if (used_r < MCW'(MAX_MSGS)) begin
          ids_r[mi_idx]  <= id_r;
          cnts_r[mi_idx] <= CW'(1);
          resp_used_r    <= 4'(used_r + MCW'(1));
        end else begin
          st_r <= ST_MSGS_FULL;
        end
      end
      S_RM_RD: begin
        // close the source message: keep it, moved down, if any item survived
        if (!scan_end && j_r >= cur_cnt) begin
          if (k_r != '0) begin
            ids_r[dst_idx]  <= ids_r[mi_idx];
            cnts_r[dst_idx] <= k_r;
            dst_r           <= dst_r + MCW'(1);
          end
          mi_r <= mi_r + MCW'(1);
          j_r  <= '0;
          k_r  <= '0;
        end
      end
      S_RM_WR: begin
        if (rdata.param == param_r) begin
          rem_r <= rem_r + RW'(1);
        end else begin
          k_r <= k_r + CW'(1);
        end
        j_r <= j_r + CW'(1);
      end
      S_VAL: begin
        if (out_acc) begin
          j_r <= j_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  crsm_item_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  crsm_decode #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dec (
    .clk     (clk),
    .ctl     (dec_ctl),
    .entry   (rdata),
    .data    (data_r),
    .param_o (dec_param),
    .value_o (dec_value)
  );

  // checks
  `CRSM_ASSERT_NOW(a_no_overlap, in_ch.ready, !out_ch.valid)
  `CRSM_ASSERT_NOW(a_used_bound, 1'b1, used_r <= MCW'(MAX_MSGS))
  `CRSM_ASSERT_NEXT(a_last_frees, out_ch.valid && out_ch.ready && out_ch.last, in_ch.ready)
  `CRSM_ASSERT_NOW(a_we_phase, mem_we, state_r == S_ADD || state_r == S_RM_WR)

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench of the CAN receive signal mapper
module testbench;
  import crsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMSG = 10;
  localparam int NITM = 8;
  localparam int FRAC = 5;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] can_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic [7:0]  param_index;
    logic [7:0]  bit_offset;
    logic [7:0]  bit_length;
    logic [15:0] gain;
  } request_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [3:0]  messages_used;
    logic [6:0]  removed_count;
    logic [7:0]  out_param;
    logic [31:0] value;
    logic        last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  crsm_in_if  req_ch ();
  crsm_out_if rsp_ch ();

  can_receive_signal_mapper_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch.sink),
    .out_ch(rsp_ch.source)
  );

  always #2 clk = ~clk;

  // Shadow copy of the mapping table
  logic [10:0] tbl_id[NMSG];
  logic        tbl_valid[NMSG];
  item_t       tbl_item[NMSG*NITM];
  int          tbl_count[NMSG];

  request_t pending_words[$];
  reply_t   expected_replies[$];
  int       mismatches = 0;
  int       send_idle_pct = 26;
  int       recv_idle_pct = 60;
  int       hold_off = 0;

  function automatic reply_t status_reply(logic [2:0] st, logic [3:0] used, logic [6:0] rm);
    reply_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.messages_used = used;
    r.removed_count = rm;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int find_message(logic [10:0] id);
    for (int i = 0; i < NMSG; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [31:0] scaled_field(item_t e, logic [63:0] data);
    logic [31:0] w;
    logic [31:0] field;
    logic [31:0] fx;
    longint prod;
    w = e.offset[5] ? data[63:32] : data[31:0];
    field = w >> e.offset[4:0];
    if (e.length < 32) field = field & ((32'd1 << e.length) - 32'd1);
    fx = field << FRAC;
    prod = longint'(signed'(fx)) * longint'(signed'(e.gain));
    prod = prod >>> FRAC;
    return prod[31:0];
  endfunction

  // Work out the replies of one request and update the shadow table
  task automatic predict_mapper(request_t q);
    int m, n, used, dst, k;
    longint removed;
    item_t e;
    reply_t r;
    case (op_t'(q.op))
      OP_CLEAR: begin
        for (int i = 0; i < NMSG; i++) begin
          tbl_valid[i] = 1'b0;
          tbl_count[i] = 0;
        end
        expected_replies.push_back(status_reply(ST_OK, 4'd0, 7'd0));
      end
      OP_ADD: begin
        if (q.bit_offset > OFS_MAX) begin
          expected_replies.push_back(status_reply(ST_BAD_OFFSET, 4'd0, 7'd0));
        end else if (q.bit_length == 0 || q.bit_length > LEN_MAX) begin
          expected_replies.push_back(status_reply(ST_BAD_LENGTH, 4'd0, 7'd0));
        end else begin
          m = find_message(q.can_id);
          if (m < 0) begin
            for (int i = 0; i < NMSG; i++)
              if (!tbl_valid[i] && m < 0) m = i;
            if (m >= 0) begin
              tbl_valid[m] = 1'b1;
              tbl_id[m] = q.can_id;
              tbl_count[m] = 0;
            end
          end
          if (m < 0) begin
            expected_replies.push_back(status_reply(ST_MSGS_FULL, 4'd0, 7'd0));
          end else if (tbl_count[m] >= NITM) begin
            expected_replies.push_back(status_reply(ST_ITEMS_FULL, 4'd0, 7'd0));
          end else begin
            tbl_item[m*NITM+tbl_count[m]] =
                '{q.param_index, q.gain, q.bit_offset[5:0], q.bit_length[5:0]};
            tbl_count[m]++;
            used = 0;
            for (int i = 0; i < NMSG; i++) if (tbl_valid[i]) used++;
            expected_replies.push_back(status_reply(ST_OK, 4'(used), 7'd0));
          end
        end
      end
      OP_REMOVE: begin
        removed = 0;
        dst = 0;
        for (int s = 0; s < NMSG; s++) begin
          if (tbl_valid[s]) begin
            k = 0;
            for (int j = 0; j < tbl_count[s]; j++) begin
              e = tbl_item[s*NITM+j];
              if (e.param == q.param_index) begin
                removed++;
              end else begin
                tbl_item[dst*NITM+k] = e;
                k++;
              end
            end
            if (k > 0) begin
              tbl_id[dst] = tbl_id[s];
              tbl_count[dst] = k;
              dst++;
            end
          end
        end
        for (int j = 0; j < NMSG; j++) begin
          tbl_valid[j] = j < dst;
          if (j >= dst) tbl_count[j] = 0;
        end
        expected_replies.push_back(status_reply(ST_OK, 4'd0, removed[6:0]));
      end
      default: begin
        m = -1;
        if (q.frame_length == FRAME_LEN && q.can_id != SERVICE_ID) m = find_message(q.can_id);
        n = (m >= 0) ? tbl_count[m] : 0;
        if (n == 0) expected_replies.push_back(status_reply(ST_NO_MATCH, 4'd0, 7'd0));
        for (int j = 0; j < n; j++) begin
          e = tbl_item[m*NITM+j];
          r = '0;
          r.kind = KIND_VALUE;
          r.out_param = e.param;
          r.value = scaled_field(e, q.frame_data);
          r.last = (j == n - 1);
          expected_replies.push_back(r);
        end
      end
    endcase
  endtask

  function automatic request_t make_request(logic [1:0] op, logic [10:0] id, logic [7:0] p,
                                            logic [7:0] ofs, logic [7:0] len, logic [15:0] g);
    request_t q;
    q.op = op;
    q.can_id = id;
    q.frame_length = 4'($urandom_range(0, 15));
    q.frame_data = {$urandom, $urandom};
    q.param_index = p;
    q.bit_offset = ofs;
    q.bit_length = len;
    q.gain = g;
    return q;
  endfunction

  function automatic request_t make_frame(logic [10:0] id, logic [63:0] data);
    request_t q;
    q = make_request(OP_FRAME, id, 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom));
    q.frame_length = FRAME_LEN;
    q.frame_data = data;
    return q;
  endfunction

  // Driver: offer the oldest pending word, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_mapper(pending_words.pop_front());
      end
      if ((!req_ch.valid || req_ch.ready) && pending_words.size() != 0 &&
          !(req_ch.valid && req_ch.ready && pending_words.size() == 0)) begin
        if ($urandom_range(0, 99) >= send_idle_pct) begin
          req_ch.valid <= 1'b1;
          {req_ch.op, req_ch.can_id, req_ch.frame_length, req_ch.frame_data,
           req_ch.param_index, req_ch.bit_offset, req_ch.bit_length, req_ch.gain}
              <= pending_words[0];
        end else begin
          req_ch.valid <= 1'b0;
        end
      end else if (req_ch.valid && req_ch.ready) begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Hold-off counter: count the long receiver stall down, one per cycle
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Monitor: compare each reply word with the oldest expectation
  always @(posedge clk) begin
    reply_t got;
    reply_t exp_r;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.kind, rsp_ch.status, rsp_ch.messages_used, rsp_ch.removed_count,
               rsp_ch.out_param, rsp_ch.value, rsp_ch.last};
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected reply word %h", got);
        end else begin
          exp_r = expected_replies.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: expected %h got %h", exp_r, got);
          end
        end
      end
      if (hold_off > 0) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    {req_ch.op, req_ch.can_id, req_ch.frame_length, req_ch.frame_data,
     req_ch.param_index, req_ch.bit_offset, req_ch.bit_length, req_ch.gain} = '0;
    rsp_ch.ready = 1'b0;
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus
  initial begin
    logic [10:0] ids[6];
    int pick;
    for (int i = 0; i < NMSG; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_count[i] = 0;
      tbl_id[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: checks, extremes, full lists, full table, service id, remove
    pending_words.push_back(make_request(OP_CLEAR, 0, 0, 0, 1, 0));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 1, 64, 8, 1));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 1, 255, 0, 1));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 1, 63, 0, 1));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 1, 0, 33, 1));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 1, 0, 255, 1));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 8'hff, 0, 32, 16'h7fff));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 8'h00, 63, 32, 16'h8000));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 3, 31, 1, 16'hffff));
    pending_words.push_back(make_request(OP_ADD, 11'h100, 4, 32, 16, 16'h0020));
    for (int i = 0; i < 5; i++)
      pending_words.push_back(make_request(OP_ADD, 11'h100, 5, 8'(i * 7), 5,
                                           16'($urandom)));
    pending_words.push_back(make_frame(11'h100, 64'hffff_ffff_ffff_ffff));
    pending_words.push_back(make_frame(11'h100, 64'h8000_0001_7fff_fffe));
    pending_words.push_back(make_frame(11'h100, 64'h0));
    for (int i = 0; i < NMSG; i++)
      pending_words.push_back(make_request(OP_ADD, 11'(11'h7ff - i), 9, 0, 8, 1));
    pending_words.push_back(make_request(OP_ADD, SERVICE_ID, 9, 0, 8, 1));
    pending_words.push_back(make_frame(SERVICE_ID, 64'h1234));
    pending_words.push_back(make_request(OP_REMOVE, 0, 5, 0, 0, 0));
    pending_words.push_back(make_request(OP_REMOVE, 0, 9, 0, 0, 0));
    pending_words.push_back(make_frame(11'h100, {$urandom, $urandom}));

    // Random: mostly adds and matching frames over a small id pool
    for (int i = 0; i < 6; i++) ids[i] = 11'($urandom);
    ids[0] = SERVICE_ID;
    for (int n = 0; n < 400; n++) begin
      if (n == 130) begin
        wait (pending_words.size() == 0 && expected_replies.size() == 0);
        send_idle_pct = 60;
        recv_idle_pct = 26;
      end
      if (n == 260) begin
        wait (pending_words.size() == 0 && expected_replies.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 300;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        pending_words.push_back(make_request(OP_CLEAR, 11'($urandom), 8'($urandom),
                                             8'($urandom), 8'($urandom), 16'($urandom)));
      end else if (pick < 40) begin
        pending_words.push_back(make_request(OP_ADD, ids[$urandom_range(0, 5)],
            8'($urandom_range(0, 7)),
            8'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 63)),
            8'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 32)),
            16'($urandom)));
      end else if (pick < 47) begin
        pending_words.push_back(make_request(OP_REMOVE, 11'($urandom),
                                             8'($urandom_range(0, 8)), 8'($urandom),
                                             8'($urandom), 16'($urandom)));
      end else if (pick < 90) begin
        pending_words.push_back(make_frame(ids[$urandom_range(0, 5)], {$urandom, $urandom}));
      end else begin
        pending_words.push_back(make_request(OP_FRAME, 11'($urandom), 8'($urandom),
                                             8'($urandom), 8'($urandom), 16'($urandom)));
      end
    end

    wait (pending_words.size() == 0 && expected_replies.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- can_receive_signal_mapper_top.f -----
+incdir+rtl
rtl/crsm_pkg.sv
rtl/crsm_if.sv
rtl/crsm_item_mem.sv
rtl/crsm_decode.sv
rtl/can_receive_signal_mapper_top.sv
verif/testbench.sv
